// ===== design/bsm_pkg.sv =====
// ----------------------------------------------------------------------------
// bsm_pkg: shared widths and sequencer states for the bounding sphere merge
// Holds the field widths and the state encoding used by the merge sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
package bsm_pkg;
  localparam int CoordBits = 32;
  localparam int RadBits   = CoordBits - 1;
  localparam int SqBits    = 2 * CoordBits + 2;   // sum of three squares
  localparam int RootBits  = SqBits / 2;
  localparam int ProdBits  = 2 * CoordBits + 1;   // |v| * k
  localparam int CntBits   = 7;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic [RadBits-1:0]          rad_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_ACC, ST_ROOT, ST_DECIDE, ST_MUL, ST_DIV, ST_APPLY, ST_OUT
  } state_t;
endpackage
`default_nettype wire

// ===== design/bsm_serial_mul.sv =====
// ----------------------------------------------------------------------------
// bsm_serial_mul: unsigned shift-and-add multiplier
// Consumes one multiplier bit per cycle; done marks the last bit, with prod valid.
// ----------------------------------------------------------------------------
`default_nettype none
module bsm_serial_mul (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [bsm_pkg::CoordBits+1:0]   a,
  input  wire logic [bsm_pkg::CoordBits-1:0]   b,
  output logic                                 done,
  output logic [bsm_pkg::ProdBits:0]           prod
);
  import bsm_pkg::*;

  logic [ProdBits:0]    acc_r, acc_nxt;
  logic [ProdBits:0]    mc_r, mc_nxt;
  logic [CoordBits-1:0] mp_r, mp_nxt;
  logic [CntBits-1:0]   cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;

  // Add the shifted multiplicand for each set multiplier bit
  always_comb begin
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      acc_nxt  = '0;
      mc_nxt   = (ProdBits+1)'(a);
      mp_nxt   = b;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mp_r[0]) acc_nxt = acc_r + mc_r;
      mc_nxt  = mc_r << 1;
      mp_nxt  = mp_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntBits'(CoordBits - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
  end

  assign done = busy_r && cnt_r == CntBits'(CoordBits - 1) && !start;
  assign prod = mp_r[0] ? acc_r + mc_r : acc_r;
endmodule
`default_nettype wire

// ===== design/bounding_sphere_merge.sv =====
// ----------------------------------------------------------------------------
// bounding_sphere_merge: running 3-D bounding sphere union
// Loads or merges each incoming sphere into the running sphere, bit-serially.
// ----------------------------------------------------------------------------
//  channel | ports                         | direction
//  in      | in_valid/in_ready, first,     | into block
//          | in_x, in_y, in_z, in_r        |
//  out     | out_valid/out_ready, out_x..r | out of block
//
// A load word only registers the sphere. A merge runs three serial squarings,
// a 33-step restoring square root, then, unless one sphere contains the other,
// for each axis a serial multiply and a 66-step restoring division, all one
// bit per cycle.
// Reset clears the running sphere to zero. One word is held at a time; the
// result register holds until out_ready, and the next word is taken after.
`default_nettype none
module bounding_sphere_merge (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  first,
  input  wire bsm_pkg::coord_t       in_x,
  input  wire bsm_pkg::coord_t       in_y,
  input  wire bsm_pkg::coord_t       in_z,
  input  wire bsm_pkg::rad_t         in_r,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output bsm_pkg::coord_t            out_x,
  output bsm_pkg::coord_t            out_y,
  output bsm_pkg::coord_t            out_z,
  output bsm_pkg::rad_t              out_r
);
  import bsm_pkg::*;

  localparam int VBits = CoordBits + 1;
  localparam coord_t CoordHi = {1'b0, {(CoordBits-1){1'b1}}};
  localparam coord_t CoordLo = {1'b1, {(CoordBits-1){1'b0}}};

  state_t state_r, state_nxt;
  coord_t cx_r [3];
  rad_t   cr_r;
  coord_t ic_r [3];
  rad_t   ir_r;
  logic signed [VBits-1:0] v_r [3];
  logic [1:0]              ax_r;
  logic [SqBits-1:0]       s_r;
  logic [SqBits-1:0]       rem_r;       // sqrt remainder
  logic [RootBits-1:0]     d_r;
  logic [CntBits-1:0]      cnt_r;
  logic [CoordBits+1:0]    k_r;
  logic [ProdBits:0]       num_r;       // dividend
  logic [RootBits+1:0]     drem_r;      // division remainder
  logic [ProdBits:0]       q_r;
  logic                    out_valid_r;
  logic                    mul_run_r;

  // multiplier hookup
  logic                    mul_start, mul_done;
  logic [CoordBits+1:0]    mul_a;
  logic [CoordBits-1:0]    mul_b;
  logic [ProdBits:0]       mul_p;
  logic [CoordBits:0]      vmag;

  assign vmag = v_r[ax_r][VBits-1] ? VBits'(-v_r[ax_r]) : VBits'(v_r[ax_r]);
  assign mul_a = state_r == ST_SQ ? (CoordBits+2)'(vmag) : k_r;
  assign mul_b = CoordBits'(vmag);
  // start once on entry to a multiply state, when its operands are settled
  assign mul_start = (state_r == ST_SQ || state_r == ST_MUL) && !mul_run_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_run_r <= 1'b0;
    end else if (mul_start) begin
      mul_run_r <= 1'b1;
    end else if (mul_done) begin
      mul_run_r <= 1'b0;
    end
  end

  bsm_serial_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_p)
  );

  // square root step values
  logic [RootBits+1:0] trial;
  logic [SqBits-1:0]   rem_sh;
  logic [1:0]          pair;
  assign pair   = s_r[SqBits-1 -: 2];
  assign rem_sh = {rem_r[SqBits-3:0], pair};
  assign trial  = {d_r, 2'b01};

  // division step values
  logic [RootBits+1:0] drem_sh;
  logic [RootBits+1:0] den;
  assign drem_sh = {drem_r[RootBits:0], num_r[ProdBits]};
  assign den     = (RootBits+2)'({d_r, 1'b0});

  // decision values
  logic [RootBits:0] dr, r1e, r2e;
  logic              contain, r1_lt_r2;
  logic [RootBits+1:0] nr;
  assign r1e      = (RootBits+1)'(cr_r);
  assign r2e      = (RootBits+1)'(ir_r);
  assign r1_lt_r2 = cr_r < ir_r;
  assign dr       = r1_lt_r2 ? r2e - r1e : r1e - r2e;
  assign contain  = (RootBits+1)'(d_r) <= dr;
  assign nr       = ((RootBits+2)'(d_r) + (RootBits+2)'(cr_r) + (RootBits+2)'(ir_r)) >> 1;

  // apply offset with clamp
  logic signed [ProdBits+2:0] cnew;
  coord_t                     cclamp;
  assign cnew = v_r[ax_r][VBits-1]
              ? (ProdBits+3)'(cx_r[ax_r]) - $signed({2'b0, q_r})
              : (ProdBits+3)'(cx_r[ax_r]) + $signed({2'b0, q_r});
  always_comb begin
    if (cnew > (ProdBits+3)'(CoordHi)) cclamp = CoordHi;
    else if (cnew < (ProdBits+3)'(CoordLo)) cclamp = CoordLo;
    else cclamp = CoordBits'(cnew);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid && !out_valid_r) state_nxt = first ? ST_OUT : ST_SQ;
      ST_SQ:     if (mul_done) state_nxt = ST_ACC;
      ST_ACC:    state_nxt = ax_r == 2'd2 ? ST_ROOT : ST_SQ;
      ST_ROOT:   if (cnt_r == CntBits'(RootBits - 1)) state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = contain ? ST_OUT : ST_MUL;
      ST_MUL:    if (mul_done) state_nxt = ST_DIV;
      ST_DIV:    if (cnt_r == CntBits'(ProdBits)) state_nxt = ST_APPLY;
      ST_APPLY:  state_nxt = ax_r == 2'd2 ? ST_OUT : ST_MUL;
      ST_OUT:    state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the handshake
  always_comb begin
    in_ready = state_r == ST_IDLE && !out_valid_r;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cx_r[0] <= '0; cx_r[1] <= '0; cx_r[2] <= '0;
      cr_r <= '0;
      ax_r <= '0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: if (in_valid && !out_valid_r) begin
          ic_r[0] <= in_x; ic_r[1] <= in_y; ic_r[2] <= in_z; ir_r <= in_r;
          v_r[0] <= VBits'(in_x) - VBits'(cx_r[0]);
          v_r[1] <= VBits'(in_y) - VBits'(cx_r[1]);
          v_r[2] <= VBits'(in_z) - VBits'(cx_r[2]);
          ax_r  <= '0;
          s_r   <= '0;
          if (first) begin
            cx_r[0] <= in_x; cx_r[1] <= in_y; cx_r[2] <= in_z; cr_r <= in_r;
          end
        end
        ST_SQ: if (mul_done) s_r <= s_r + SqBits'(mul_p);
        ST_ACC: begin
          if (ax_r == 2'd2) begin
            ax_r <= '0; cnt_r <= '0; rem_r <= '0; d_r <= '0;
          end else ax_r <= ax_r + 1'b1;
        end
        ST_ROOT: begin
          if ((RootBits+2)'(rem_sh) >= trial && rem_sh[SqBits-1:RootBits+2] == '0) begin
            rem_r <= rem_sh - SqBits'(trial);
            d_r   <= {d_r[RootBits-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            d_r   <= {d_r[RootBits-2:0], 1'b0};
          end
          s_r   <= s_r << 2;
          cnt_r <= cnt_r + 1'b1;
        end
        ST_DECIDE: begin
          ax_r <= '0;
          k_r  <= r1_lt_r2 ? (CoordBits+2)'(d_r) + (CoordBits+2)'(dr)
                           : (CoordBits+2)'(d_r) - (CoordBits+2)'(dr);
          if (contain) begin
            if (r1_lt_r2) begin
              cx_r[0] <= ic_r[0]; cx_r[1] <= ic_r[1]; cx_r[2] <= ic_r[2]; cr_r <= ir_r;
            end
          end else begin
            cr_r <= nr > (RootBits+2)'({RadBits{1'b1}}) ? {RadBits{1'b1}} : RadBits'(nr);
          end
        end
        ST_MUL: if (mul_done) begin
          num_r <= mul_p; drem_r <= '0; q_r <= '0; cnt_r <= '0;
        end
        ST_DIV: begin
          if (drem_sh >= den) begin
            drem_r <= drem_sh - den;
            q_r    <= {q_r[ProdBits-1:0], 1'b1};
          end else begin
            drem_r <= drem_sh;
            q_r    <= {q_r[ProdBits-1:0], 1'b0};
          end
          num_r <= num_r << 1;
          cnt_r <= cnt_r + 1'b1;
        end
        ST_APPLY: begin
          cx_r[ax_r] <= cclamp;
          ax_r <= ax_r + 1'b1;
        end
        ST_OUT: out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_x = cx_r[0];
  assign out_y = cx_r[1];
  assign out_z = cx_r[2];
  assign out_r = cr_r;
endmodule
`default_nettype wire
